[hdl/zbuffer_triangle_rasterizer_top_assert.svh]
// assertion macros shared by the checker
`ifndef ZBUFFER_TRIANGLE_RASTERIZER_TOP_ASSERT_SVH
`define ZBUFFER_TRIANGLE_RASTERIZER_TOP_ASSERT_SVH

// condition in the same cycle
`define ZBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("zbr assertion failed");

// condition in the next cycle
`define ZBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("zbr assertion failed");

`endif

[hdl/zbr_pkg.sv]
package zbr_pkg;

	localparam int CANVAS_COLUMNS_DEF = 80;
	localparam int CANVAS_ROWS_DEF    = 40;

	localparam logic [7:0]         SPACE_CHAR  = 8'd32;
	localparam logic signed [15:0] DEPTH_FLOOR = 16'sh8000;

	// shared multiplier operand widths
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// depth divider widths
	localparam int NUM_W = 48;
	localparam int DEN_W = 34;
	localparam int QUO_W = 17;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_DRAW  = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [15:0] corner_a_x;
		logic signed [15:0] corner_a_y;
		logic signed [15:0] corner_a_depth;
		logic signed [15:0] corner_b_x;
		logic signed [15:0] corner_b_y;
		logic signed [15:0] corner_b_depth;
		logic signed [15:0] corner_c_x;
		logic signed [15:0] corner_c_y;
		logic signed [15:0] corner_c_depth;
		logic [7:0]         shade_char;
		logic [5:0]         read_row;
	} request_t;

	typedef struct packed {
		logic [63:0] row_chars;
		logic        last_of_row;
	} result_t;

	typedef struct packed {
		logic             done;
		logic             rem_nz;
		logic [QUO_W-1:0] quot;
	} div_res_t;

endpackage

[hdl/zbr_mul.sv]
module zbr_mul
	import zbr_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] op_a,
	input  logic signed [MUL_B_W-1:0] op_b,
	output logic signed [MUL_P_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
	end

endmodule

[hdl/zbr_div.sv]
module zbr_div
	import zbr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output div_res_t         res
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [DEN_W:0]   r_q;
	logic [QUO_W-1:0] n_q;
	logic [QUO_W-1:0] q_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	// one restoring step per cycle
	always_comb begin
		trial = {r_q[DEN_W-1:0], n_q[QUO_W-1]};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(QUO_W);
				r_q   <= (DEN_W + 1)'(num[NUM_W-1:QUO_W]);
				n_q   <= num[QUO_W-1:0];
				den_q <= den;
				q_q   <= '0;
			end else if (run_q) begin
				r_q   <= ge ? (trial - {1'b0, den_q}) : trial;
				n_q   <= {n_q[QUO_W-2:0], 1'b0};
				q_q   <= {q_q[QUO_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.done   = done_q;
	assign res.rem_nz = r_q != '0;
	assign res.quot   = q_q;

endmodule

[hdl/zbuffer_triangle_rasterizer_top.sv]
// clear: busy while every cell is written, one cell written per cycle, no result
// draw: setup, then per box pixel edge tests ST_WA0..ST_TEST; for a pixel in the triangle,
// ST_ZA..ST_WRITE use the 17-step serial depth divider; busy until the box is done
// read: one byte per cycle, eight bytes to each result word, shown on strobe, no stall;
// a row number past the canvas is ignored
// reset runs a clearing pass over every cell with busy high
module zbuffer_triangle_rasterizer_top
	import zbr_pkg::*;
#(
	parameter int CANVAS_COLUMNS = CANVAS_COLUMNS_DEF,
	parameter int CANVAS_ROWS    = CANVAS_ROWS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     strobe,
	output result_t  result
);

	localparam int CELLS     = CANVAS_COLUMNS * CANVAS_ROWS;
	localparam int CELL_W    = $clog2(CELLS);
	localparam int X_W       = $clog2(CANVAS_COLUMNS);
	localparam int Y_W       = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
	localparam int WORDS     = (CANVAS_COLUMNS + 7) / 8;
	localparam int COL_W     = $clog2(WORDS * 8);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(WORDS * 8 - 1);
	localparam logic signed [12:0] COL_MAX = 13'(CANVAS_COLUMNS - 1);
	localparam logic signed [12:0] ROW_MAX = 13'(CANVAS_ROWS - 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLEAR, ST_READ,
		ST_AREA0, ST_AREA1, ST_AREA2,
		ST_WA0, ST_WA1, ST_WB0, ST_WB1, ST_TEST,
		ST_ZA, ST_ZB, ST_ZC, ST_ZSUM, ST_DIV, ST_WRITE
	} state_t;

	state_t   state_q;
	request_t req_q;

	// canvas memories
	logic [7:0]         char_mem [CELLS];
	logic signed [15:0] depth_mem [CELLS];
	logic [7:0]         char_rd_q;
	logic signed [15:0] depth_rd_q;
	logic [CELL_W-1:0]  char_rd_addr;
	logic               mem_wr;
	logic [7:0]         wr_char;
	logic signed [15:0] wr_depth;

	// scan position
	logic [CELL_W-1:0] cell_q;
	logic [CELL_W-1:0] row_base_q;
	logic [X_W-1:0]    px_q, lox_q, hix_q;
	logic [Y_W-1:0]    py_q, hiy_q;

	// readout
	logic [CELL_W-1:0] rd_base_q;
	logic [COL_W-1:0]  col_q, lag_col_q;
	logic              issue_done_q, lag_v_q, lag_in_q;
	logic [63:0]       word_q;
	logic              strobe_q, last_q;
	logic [63:0]       chars_q;

	// triangle arithmetic
	logic                      area_neg_q;
	logic signed [35:0]        area_q, wa_q, wb_q, wc_q;
	logic signed [MUL_P_W-1:0] acc_q;
	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [MUL_A_W-1:0] op_a;
	logic signed [MUL_B_W-1:0] op_b;
	logic                      z_neg_q;
	logic signed [15:0]        z_q;
	logic                      div_start;
	logic [NUM_W-1:0]          div_num;
	div_res_t                  div_res;

	logic signed [16:0] d_bc_y, d_cb_x, d_ca_y, d_ac_x, d_ac_y, dqx, dqy;
	logic signed [35:0] sum36, signed_w, wc_next;
	logic signed [MUL_P_W-1:0] num_total;
	logic signed [11:0] minx, maxx, miny, maxy;
	logic signed [12:0] lox_c, hix_c, loy_c, hiy_c;
	logic               box_empty, advance;
	logic signed [17:0] z_full;

	function automatic logic signed [11:0] min3(input logic signed [15:0] a, b, c);
		logic signed [15:0] m;
		m = (a < b) ? a : b;
		m = (m < c) ? m : c;
		return m[15:4];
	endfunction

	function automatic logic signed [11:0] max3(input logic signed [15:0] a, b, c);
		logic signed [15:0] m;
		m = (a > b) ? a : b;
		m = (m > c) ? m : c;
		return m[15:4];
	endfunction

	assign busy = state_q != ST_IDLE;

	// edge differences in 1/16 pixel units
	always_comb begin
		d_bc_y = 17'(req_q.corner_b_y) - 17'(req_q.corner_c_y);
		d_cb_x = 17'(req_q.corner_c_x) - 17'(req_q.corner_b_x);
		d_ca_y = 17'(req_q.corner_c_y) - 17'(req_q.corner_a_y);
		d_ac_x = 17'(req_q.corner_a_x) - 17'(req_q.corner_c_x);
		d_ac_y = 17'(req_q.corner_a_y) - 17'(req_q.corner_c_y);
		dqx    = 17'({1'b0, px_q, 4'b0000}) - 17'(req_q.corner_c_x);
		dqy    = 17'({1'b0, py_q, 4'b0000}) - 17'(req_q.corner_c_y);
	end

	// bounding box floored to pixels and clipped to the canvas
	always_comb begin
		minx  = min3(req_q.corner_a_x, req_q.corner_b_x, req_q.corner_c_x);
		maxx  = max3(req_q.corner_a_x, req_q.corner_b_x, req_q.corner_c_x);
		miny  = min3(req_q.corner_a_y, req_q.corner_b_y, req_q.corner_c_y);
		maxy  = max3(req_q.corner_a_y, req_q.corner_b_y, req_q.corner_c_y);
		lox_c = (minx < 12'sd0) ? 13'sd0 : 13'(minx);
		loy_c = (miny < 12'sd0) ? 13'sd0 : 13'(miny);
		hix_c = (13'(maxx) > COL_MAX) ? COL_MAX : 13'(maxx);
		hiy_c = (13'(maxy) > ROW_MAX) ? ROW_MAX : 13'(maxy);
		box_empty = (lox_c > hix_c) || (loy_c > hiy_c);
	end

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			ST_AREA0: begin op_a = MUL_A_W'(d_bc_y); op_b = d_ac_x; end
			ST_AREA1: begin op_a = MUL_A_W'(d_cb_x); op_b = d_ac_y; end
			ST_WA0:   begin op_a = MUL_A_W'(d_bc_y); op_b = dqx; end
			ST_WA1:   begin op_a = MUL_A_W'(d_cb_x); op_b = dqy; end
			ST_WB0:   begin op_a = MUL_A_W'(d_ca_y); op_b = dqx; end
			ST_WB1:   begin op_a = MUL_A_W'(d_ac_x); op_b = dqy; end
			ST_ZA:    begin op_a = wa_q[MUL_A_W-1:0]; op_b = 17'(req_q.corner_a_depth); end
			ST_ZB:    begin op_a = wb_q[MUL_A_W-1:0]; op_b = 17'(req_q.corner_b_depth); end
			ST_ZC:    begin op_a = wc_q[MUL_A_W-1:0]; op_b = 17'(req_q.corner_c_depth); end
			default:  begin op_a = '0; op_b = '0; end
		endcase
	end

	zbr_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	// edge sum, oriented by the triangle winding
	always_comb begin
		sum36     = 36'(acc_q) + 36'(prod_q);
		signed_w  = area_neg_q ? -sum36 : sum36;
		wc_next   = area_q - wa_q - signed_w;
		num_total = acc_q + prod_q;
		div_start = state_q == ST_ZSUM;
		div_num   = num_total[MUL_P_W-1] ? NUM_W'(-num_total) : NUM_W'(num_total);
		// floor of the quotient for a negative numerator
		z_full    = z_neg_q ? -(18'(div_res.quot) + 18'(div_res.rem_nz))
		                    : 18'(div_res.quot);
	end

	zbr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (area_q[DEN_W-1:0]),
		.res    (div_res)
	);

	// store write: clearing pass or a nearer covered pixel
	always_comb begin
		mem_wr   = 1'b0;
		wr_char  = SPACE_CHAR;
		wr_depth = DEPTH_FLOOR;
		advance  = 1'b0;
		unique case (state_q)
			ST_CLEAR: mem_wr = 1'b1;
			ST_TEST:  advance = (signed_w < 0) || (wa_q < 0) || (wc_next < 0);
			ST_WRITE: begin
				advance  = 1'b1;
				mem_wr   = z_q > depth_rd_q;
				wr_char  = req_q.shade_char;
				wr_depth = z_q;
			end
			default: ;
		endcase
		char_rd_addr = (9'(col_q) < 9'(CANVAS_COLUMNS)) ? (rd_base_q + CELL_W'(col_q))
		                                               : rd_base_q;
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			char_mem[cell_q]  <= wr_char;
			depth_mem[cell_q] <= wr_depth;
		end
		char_rd_q  <= char_mem[char_rd_addr];
		depth_rd_q <= depth_mem[cell_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cell_q       <= '0;
			strobe_q     <= 1'b0;
			lag_v_q      <= 1'b0;
			issue_done_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q <= request;
						priority case (request.func)
							FUNC_CLEAR: begin
								cell_q  <= '0;
								state_q <= ST_CLEAR;
							end
							FUNC_DRAW: state_q <= ST_AREA0;
							FUNC_READ: begin
								if (9'(request.read_row) < 9'(CANVAS_ROWS)) begin
									rd_base_q    <= CELL_W'(request.read_row) *
									                CELL_W'(CANVAS_COLUMNS);
									col_q        <= '0;
									issue_done_q <= 1'b0;
									lag_v_q      <= 1'b0;
									state_q      <= ST_READ;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CLEAR: begin
					if (cell_q == CELL_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						cell_q <= cell_q + 1'b1;
					end
				end
				ST_READ: begin
					// one byte issued and one returned per cycle, each return trailing its issue by the registered memory read
					lag_v_q <= !issue_done_q;
					if (!issue_done_q) begin
						lag_col_q    <= col_q;
						lag_in_q     <= 9'(col_q) < 9'(CANVAS_COLUMNS);
						col_q        <= col_q + 1'b1;
						issue_done_q <= col_q == COL_LAST;
					end
					if (lag_v_q) begin
						word_q <= {(lag_in_q ? char_rd_q : 8'd0), word_q[63:8]};
						if (lag_col_q[2:0] == 3'd7) begin
							strobe_q <= 1'b1;
							chars_q  <= {(lag_in_q ? char_rd_q : 8'd0), word_q[63:8]};
							last_q   <= lag_col_q == COL_LAST;
						end
						if (lag_col_q == COL_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_AREA0: state_q <= ST_AREA1;
				ST_AREA1: begin
					acc_q   <= prod_q;
					state_q <= ST_AREA2;
				end
				ST_AREA2: begin
					// degenerate triangle or box off canvas draws nothing
					if (sum36 == '0 || box_empty) begin
						state_q <= ST_IDLE;
					end else begin
						area_neg_q <= sum36 < 0;
						area_q     <= (sum36 < 0) ? -sum36 : sum36;
						lox_q      <= lox_c[X_W-1:0];
						hix_q      <= hix_c[X_W-1:0];
						hiy_q      <= hiy_c[Y_W-1:0];
						px_q       <= lox_c[X_W-1:0];
						py_q       <= loy_c[Y_W-1:0];
						row_base_q <= CELL_W'(loy_c[Y_W-1:0]) * CELL_W'(CANVAS_COLUMNS);
						cell_q     <= CELL_W'(loy_c[Y_W-1:0]) * CELL_W'(CANVAS_COLUMNS)
						              + CELL_W'(lox_c[X_W-1:0]);
						state_q    <= ST_WA0;
					end
				end
				ST_WA0: state_q <= ST_WA1;
				ST_WA1: begin
					acc_q   <= prod_q;
					state_q <= ST_WB0;
				end
				ST_WB0: begin
					wa_q    <= signed_w;
					state_q <= ST_WB1;
				end
				ST_WB1: begin
					acc_q   <= prod_q;
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					wb_q    <= signed_w;
					wc_q    <= wc_next;
					state_q <= ST_ZA;
				end
				ST_ZA: state_q <= ST_ZB;
				ST_ZB: begin
					acc_q   <= prod_q;
					state_q <= ST_ZC;
				end
				ST_ZC: begin
					acc_q   <= num_total;
					state_q <= ST_ZSUM;
				end
				ST_ZSUM: begin
					z_neg_q <= num_total[MUL_P_W-1];
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_res.done) begin
						z_q     <= z_full[15:0];
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: ;
				default: state_q <= ST_IDLE;
			endcase

			// step to the next pixel of the box
			if (advance) begin
				if (px_q != hix_q) begin
					px_q    <= px_q + 1'b1;
					cell_q  <= cell_q + 1'b1;
					state_q <= ST_WA0;
				end else if (py_q != hiy_q) begin
					px_q       <= lox_q;
					py_q       <= py_q + 1'b1;
					row_base_q <= row_base_q + CELL_W'(CANVAS_COLUMNS);
					cell_q     <= row_base_q + CELL_W'(CANVAS_COLUMNS) + CELL_W'(lox_q);
					state_q    <= ST_WA0;
				end else begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	assign strobe             = strobe_q;
	assign result.row_chars   = chars_q;
	assign result.last_of_row = last_q;

endmodule

[hdl/zbr_checker.sv]
`include "zbuffer_triangle_rasterizer_top_assert.svh"

module zbr_checker
	import zbr_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input request_t request,
	input logic     strobe,
	input result_t  result
);

	logic read_req;
	logic work_req;
	assign read_req = start && !busy && request.func == FUNC_READ;
	assign work_req = start && !busy &&
	                  (request.func == FUNC_CLEAR || request.func == FUNC_DRAW);

	// an accepted clear or draw always occupies the block
	`ZBR_ASSERT_NEXT(a_busy_after_req, clk, arst_n, work_req, busy)
	// results never arrive back to back
	`ZBR_ASSERT_NEXT(a_strobe_spaced, clk, arst_n, strobe, !strobe)
	// a readout never starts with a result
	`ZBR_ASSERT_NEXT(a_no_early_result, clk, arst_n, read_req, !strobe)
	// a row ends only with the block going idle
	`ZBR_ASSERT_NOW(a_last_idle, clk, arst_n, strobe && result.last_of_row, !busy)

endmodule

bind zbuffer_triangle_rasterizer_top zbr_checker u_zbr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.strobe  (strobe),
	.result  (result)
);
